// File: hdl/smt_pkg.sv
// shared types and request codes for the set membership table
package smt_pkg;

	localparam logic [1:0] REQ_LOOKUP = 2'd0;
	localparam logic [1:0] REQ_INSERT = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;

	localparam int REQ_TYPE_WIDTH = 2;
	localparam int REQ_VALUE_WIDTH = 32;
	localparam int COUNT_WIDTH = 5;

	typedef enum logic [1:0] {
		OP_LOOKUP,
		OP_INSERT,
		OP_REMOVE
	} op_t;

	typedef struct packed {
		logic [REQ_TYPE_WIDTH-1:0] req_type;
		logic [REQ_VALUE_WIDTH-1:0] value;
	} req_t;

	typedef struct packed {
		logic was_present;
		logic changed;
		logic overflow;
		logic [COUNT_WIDTH-1:0] element_count;
	} rsp_t;

endpackage

// File: hdl/smt_front.sv
// request intake: decodes the request type and trims the value to the table width
module smt_front #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_ready,
	input  smt_pkg::req_t          req,
	output logic                   push_valid,
	input  logic                   push_ready,
	output smt_pkg::op_t           push_op,
	output logic [VALUE_WIDTH-1:0] push_value
);

	logic                   valid_s1;
	smt_pkg::op_t           op_s1;
	logic [VALUE_WIDTH-1:0] value_s1;
	smt_pkg::op_t           op_dec;

	assign req_ready = !valid_s1 || push_ready;

	always_comb begin
		case (req.req_type)
			smt_pkg::REQ_INSERT: op_dec = smt_pkg::OP_INSERT;
			smt_pkg::REQ_REMOVE: op_dec = smt_pkg::OP_REMOVE;
			default:             op_dec = smt_pkg::OP_LOOKUP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			op_s1    <= op_dec;
			value_s1 <= VALUE_WIDTH'(req.value);
		end
	end

	assign push_valid = valid_s1;
	assign push_op    = op_s1;
	assign push_value = value_s1;

endmodule

// File: hdl/smt_queue.sv
// two-entry queue between the intake and the table
module smt_queue #(
	parameter int WIDTH = 34
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       fill_q;
	logic             push;
	logic             pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: hdl/smt_back.sv
// entry cell array: parallel compare, then insert, remove with shift, and result register
module smt_back #(
	parameter int CAPACITY    = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pop_valid,
	output logic                   pop_ready,
	input  smt_pkg::op_t           pop_op,
	input  logic [VALUE_WIDTH-1:0] pop_value,
	output logic                   rsp_valid,
	input  logic                   rsp_ready,
	output smt_pkg::rsp_t          rsp
);

	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic {
		ST_IDLE,
		ST_CMP
	} state_t;

	state_t                 state_q;
	smt_pkg::op_t           op_s1;
	logic [VALUE_WIDTH-1:0] value_s1;
	logic [CAPACITY-1:0]    match_s1;
	logic [CAPACITY-1:0]    hit;
	logic [CAPACITY-1:0]    shift;
	logic [VALUE_WIDTH-1:0] cell_q [CAPACITY];
	logic [VALUE_WIDTH-1:0] cell_next [CAPACITY];
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          new_count;
	logic                   rsp_valid_q;
	smt_pkg::rsp_t          rsp_q;
	logic                   apply;
	logic                   present;
	logic                   full;
	logic                   do_ins;
	logic                   do_rem;
	logic                   ovf;

	assign pop_ready = (state_q == ST_IDLE);
	assign apply     = (state_q == ST_CMP) && (!rsp_valid_q || rsp_ready);
	assign present   = |match_s1;
	assign full      = (count_q == CW'(CAPACITY));
	assign do_ins    = (op_s1 == smt_pkg::OP_INSERT) && !present && !full;
	assign do_rem    = (op_s1 == smt_pkg::OP_REMOVE) && present;
	assign ovf       = (op_s1 == smt_pkg::OP_INSERT) && !present && full;

	always_comb begin
		if (do_ins) begin
			new_count = count_q + CW'(1);
		end else if (do_rem) begin
			new_count = count_q - CW'(1);
		end else begin
			new_count = count_q;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		// entries at or above the matching slot move down one place on remove
		assign hit[i]   = (cell_q[i] == pop_value) && (CW'(i) < count_q);
		assign shift[i] = |match_s1[i:0];

		if (i < CAPACITY - 1) begin : g_mid
			assign cell_next[i] = cell_q[i+1];
		end else begin : g_last
			assign cell_next[i] = cell_q[i];
		end

		always_ff @(posedge clk) begin
			if (apply) begin
				if (do_rem && shift[i]) begin
					cell_q[i] <= cell_next[i];
				end else if (do_ins && (count_q == CW'(i))) begin
					cell_q[i] <= value_s1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			op_s1    <= pop_op;
			value_s1 <= pop_value;
			match_s1 <= hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						state_q <= ST_CMP;
					end
					if (rsp_ready) begin
						rsp_valid_q <= 1'b0;
					end
				end
				ST_CMP: begin
					if (apply) begin
						state_q             <= ST_IDLE;
						count_q             <= new_count;
						rsp_valid_q         <= 1'b1;
						rsp_q.was_present   <= present;
						rsp_q.changed       <= do_ins || do_rem;
						rsp_q.overflow      <= ovf;
						rsp_q.element_count <= smt_pkg::COUNT_WIDTH'(new_count);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |-> $onehot0(match_s1))
		else $error("value stored in more than one entry");

	a_ovf_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(rsp_q.overflow && rsp_q.changed))
		else $error("overflow together with change");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(apply && !do_ins && !do_rem) |=> (count_q == $past(count_q)))
		else $error("count moved without a change");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_ready) |=> (rsp_valid_q && $stable(rsp_q)))
		else $error("result dropped while stalled");
`endif

endmodule

// File: hdl/set_membership_table.sv
// top level of the set membership table
// Keeps a set of up to CAPACITY distinct values and answers one lookup, insert or remove
// per item with presence, change, overflow and the new element count. An item passes an
// intake register and a two-entry queue, then the entry cell array: a compare step in which
// every cell compares its value at once, then an update step in which the array inserts at
// the tail or removes and shifts the later entries down. The cell array takes a new item
// only once it has finished the last one, and its update waits while an earlier result is
// still held. The result is registered. Request code 3 is served as a lookup, and value
// bits above VALUE_WIDTH are ignored.
module set_membership_table #(
	parameter int CAPACITY    = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  smt_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output smt_pkg::rsp_t rsp
);

	localparam int QW = VALUE_WIDTH + 2;

	logic                   push_valid;
	logic                   push_ready;
	smt_pkg::op_t           push_op;
	logic [VALUE_WIDTH-1:0] push_value;
	logic                   pop_valid;
	logic                   pop_ready;
	logic [QW-1:0]          pop_data;

	smt_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_op    (push_op),
		.push_value (push_value)
	);

	smt_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  ({push_op, push_value}),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	smt_back #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_op    (smt_pkg::op_t'(pop_data[QW-1:VALUE_WIDTH])),
		.pop_value (pop_data[VALUE_WIDTH-1:0]),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
